// ----- rtl/ssfbd_pkg.sv -----
// Package for the sequence store: sizes, opcodes, port packing widths and the
// tag that travels with each read towards the result stage.
// No dependencies.
package ssfbd_pkg;

   // Store geometry
   localparam int CAPACITY = 32;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Field widths
   localparam int OP_W   = 2;
   localparam int DATA_W = 32;
   localparam int IDX_W  = 6;
   localparam int POS_W  = 5;
   localparam int CMP_W  = (IDX_W > CNT_W) ? IDX_W : CNT_W;

   // Packed port widths (tdata filled up to whole bytes)
   localparam int REQ_TDATA_W = ((DATA_W + IDX_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
   localparam int RSP_TUSER_W = 3;

   // Opcodes
   localparam logic [OP_W-1:0] OP_FRONT  = 2'd0;
   localparam logic [OP_W-1:0] OP_BACK   = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   // Sideband carried alongside a read issued to the result stage
   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             last;
      logic             empty_res;
      logic             dropped;
      logic             ignored;
   } rsp_tag_type;

endpackage

// ----- rtl/ssfbd_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data held while the read enable is low. No dependencies.
module ssfbd_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic [WIDTH-1:0]               wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [WIDTH-1:0]               rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/ssfbd_out.sv -----
// Result stage: takes read data from the store RAM's registered read port,
// together with its tag, and holds it in the output register under backpressure.
// Depends on ssfbd_pkg.
module ssfbd_out (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                issue,
   input  ssfbd_pkg::rsp_tag_type              tag,
   input  logic [ssfbd_pkg::DATA_W-1:0]        rd_data,
   output logic                                can_issue,
   output logic                                pend,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ssfbd_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // element, position, zero fill
   output logic [ssfbd_pkg::RSP_TUSER_W-1:0]   rsp_tuser,   // empty_res, dropped, ignored
   output logic                                rsp_tlast
);
   import ssfbd_pkg::*;

   logic                pend_ff, pend_in;
   rsp_tag_type         tag_ff;
   logic                out_v_ff, out_v_in;
   logic [DATA_W-1:0]   elem_ff;
   rsp_tag_type         otag_ff;
   logic                move;

   // word moves from RAM output into the output register
   assign move      = pend_ff && (!out_v_ff || rsp_tready);
   assign can_issue = !pend_ff || move;
   assign pend      = pend_ff;

   always_comb begin
      pend_in = pend_ff;
      if (issue) begin
         pend_in = 1'b1;
      end else if (move) begin
         pend_in = 1'b0;
      end
      out_v_in = out_v_ff;
      if (move) begin
         out_v_in = 1'b1;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         out_v_ff <= out_v_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (issue) begin
         tag_ff <= tag;
      end
      if (move) begin
         otag_ff <= tag_ff;
         elem_ff <= tag_ff.empty_res ? '0 : rd_data;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - DATA_W - POS_W){1'b0}}, otag_ff.position, elem_ff};
   assign rsp_tuser  = {otag_ff.ignored, otag_ff.dropped, otag_ff.empty_res};
   assign rsp_tlast  = otag_ff.last;

endmodule

// ----- rtl/sequence_store_front_back_delete.sv -----
// Ordered store of up to CAPACITY signed words with front insert, back append
// and indexed delete. An append, a drop, an ignored delete or a delete of the
// last element goes straight to the result stream; a front insert first shifts
// the elements up (not on an empty store) and then writes the word at the
// front; any other delete shifts the later elements down. Then one result word
// per cycle while rsp_tready is high; a stalled result word stalls the sequencer.
// Reset (synchronous, active high) empties the store; RAM contents are not cleared.
module sequence_store_front_back_delete (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ssfbd_pkg::REQ_TDATA_W-1:0]   req_tdata,   // value, index, zero fill
   input  logic [ssfbd_pkg::OP_W-1:0]          req_tuser,   // opcode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ssfbd_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // element, position, zero fill
   output logic [ssfbd_pkg::RSP_TUSER_W-1:0]   rsp_tuser,   // empty_res, dropped, ignored
   output logic                                rsp_tlast
);
   import ssfbd_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SHIFT = 2'd1;
   localparam logic [1:0] S_PUT   = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic [ADDR_W-1:0] src_ff, src_in;
   logic [ADDR_W-1:0] wsrc_ff, wsrc_in;
   logic              rpend_ff, rpend_in;
   logic              up_ff, up_in;
   logic [ADDR_W-1:0] emit_ff, emit_in;
   logic              dropped_ff, dropped_in;
   logic              ignored_ff, ignored_in;
   logic [DATA_W-1:0] val_ff;

   logic [OP_W-1:0]   op;
   logic [DATA_W-1:0] value;
   logic [IDX_W-1:0]  index;
   logic              in_acc;
   logic              full;
   logic [CMP_W-1:0]  idx_c, cnt_c;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;

   logic              out_issue, out_can, out_pend;
   rsp_tag_type       out_tag;
   logic              emit_last;

   assign op     = req_tuser;
   assign value  = req_tdata[DATA_W-1:0];
   assign index  = req_tdata[DATA_W +: IDX_W];
   assign full   = (cnt_ff == CNT_W'(CAPACITY));
   assign idx_c  = CMP_W'(index);
   assign cnt_c  = CMP_W'(cnt_ff);

   assign req_tready = (state_ff == S_IDLE) && !out_pend;
   assign in_acc     = req_tvalid && req_tready;
   assign emit_last  = (CNT_W'(emit_ff) + CNT_W'(1)) == cnt_ff;

   // sequencer: accept, shift, front write, stream out
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      left_in    = left_ff;
      src_in     = src_ff;
      wsrc_in    = wsrc_ff;
      rpend_in   = 1'b0;
      up_in      = up_ff;
      emit_in    = emit_ff;
      dropped_in = dropped_ff;
      ignored_in = ignored_ff;
      ram_we     = 1'b0;
      ram_waddr  = '0;
      ram_wdata  = value;
      ram_re     = 1'b0;
      ram_raddr  = src_ff;
      out_issue  = 1'b0;
      out_tag    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (in_acc) begin
               dropped_in = 1'b0;
               ignored_in = 1'b0;
               emit_in    = '0;
               priority if (op == OP_FRONT) begin
                  if (full) begin
                     dropped_in = 1'b1;
                     state_in   = S_EMIT;
                  end else if (cnt_ff == '0) begin
                     state_in = S_PUT;
                  end else begin
                     up_in    = 1'b1;
                     src_in   = ADDR_W'(cnt_ff - CNT_W'(1));
                     left_in  = cnt_ff;
                     state_in = S_SHIFT;
                  end
               end else if (op == OP_BACK) begin
                  if (full) begin
                     dropped_in = 1'b1;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = ADDR_W'(cnt_ff);
                     cnt_in    = cnt_ff + CNT_W'(1);
                  end
                  state_in = S_EMIT;
               end else begin
                  // delete (opcode three behaves the same)
                  if (idx_c >= cnt_c) begin
                     ignored_in = 1'b1;
                     state_in   = S_EMIT;
                  end else begin
                     cnt_in = cnt_ff - CNT_W'(1);
                     if (idx_c + CMP_W'(1) == cnt_c) begin
                        state_in = S_EMIT;
                     end else begin
                        up_in    = 1'b0;
                        src_in   = ADDR_W'(idx_c + CMP_W'(1));
                        left_in  = CNT_W'(cnt_c - CMP_W'(1) - idx_c);
                        state_in = S_SHIFT;
                     end
                  end
               end
            end
         end

         S_SHIFT: begin
            // write back the word read last cycle, one place up or down
            if (rpend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = up_ff ? (wsrc_ff + ADDR_W'(1)) : (wsrc_ff - ADDR_W'(1));
               ram_wdata = ram_rdata;
            end
            if (left_ff != '0) begin
               ram_re    = 1'b1;
               ram_raddr = src_ff;
               rpend_in  = 1'b1;
               wsrc_in   = src_ff;
               left_in   = left_ff - CNT_W'(1);
               src_in    = up_ff ? (src_ff - ADDR_W'(1)) : (src_ff + ADDR_W'(1));
            end else if (!rpend_ff) begin
               state_in = up_ff ? S_PUT : S_EMIT;
            end
         end

         S_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = val_ff;
            cnt_in    = cnt_ff + CNT_W'(1);
            state_in  = S_EMIT;
         end

         S_EMIT: begin
            out_tag.dropped = dropped_ff;
            out_tag.ignored = ignored_ff;
            if (out_can) begin
               out_issue = 1'b1;
               if (cnt_ff == '0) begin
                  out_tag.empty_res = 1'b1;
                  out_tag.last      = 1'b1;
                  state_in          = S_IDLE;
               end else begin
                  ram_re           = 1'b1;
                  ram_raddr        = emit_ff;
                  out_tag.position = POS_W'(emit_ff);
                  out_tag.last     = emit_last;
                  if (emit_last) begin
                     state_in = S_IDLE;
                  end else begin
                     emit_in = emit_ff + ADDR_W'(1);
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rpend_ff <= 1'b0;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rpend_ff <= rpend_in;
         left_ff  <= left_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      src_ff     <= src_in;
      wsrc_ff    <= wsrc_in;
      up_ff      <= up_in;
      emit_ff    <= emit_in;
      dropped_ff <= dropped_in;
      ignored_ff <= ignored_in;
      if (in_acc) begin
         val_ff <= value;
      end
   end

   ssfbd_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ssfbd_out u_out (
      .clock      (clock),
      .reset      (reset),
      .issue      (out_issue),
      .tag        (out_tag),
      .rd_data    (ram_rdata),
      .can_issue  (out_can),
      .pend       (out_pend),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("RAM read and write at the same entry");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast)
      else $error("empty result word not marked last");

   a_shift_no_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> !out_pend)
      else $error("result data pending while the store is being shifted");

endmodule
